// ===== rtl/ffsp_pkg.sv =====
// Package for the first-fit segment placer.
// Holds shared widths, status codes, operation codes of the shared unit and its result type.
// No dependencies.
`default_nettype none

package ffsp_pkg;

	localparam int MAX_SEGMENTS_DEF = 64;
	localparam int ADDR_W           = 32;
	localparam int FIELD_W          = 25;
	localparam int ORG_W            = 24;
	localparam int BANK_SHIFT       = 16;
	localparam logic [ADDR_W-1:0] MEMORY_TOP   = 32'h0100_0000;
	localparam logic [FIELD_W-1:0] LOWEST_RESET = 25'h002_0000;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_COLLIDE = 2'd1;
	localparam logic [1:0] ST_NOSPACE = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	localparam logic [2:0] OP_ROUND   = 3'd0;
	localparam logic [2:0] OP_BANKCHK = 3'd1;
	localparam logic [2:0] OP_FIT     = 3'd2;
	localparam logic [2:0] OP_ADD     = 3'd3;
	localparam logic [2:0] OP_HIT     = 3'd4;
	localparam logic [2:0] OP_GT      = 3'd5;

	typedef struct packed {
		logic [ADDR_W-1:0] y;
		logic              flag;
	} alu_res_t;

endpackage

`default_nettype wire

// ===== rtl/ffsp_alu.sv =====
// Shared 32-bit arithmetic and compare unit of the segment placer.
// Depends on ffsp_pkg for operation codes and the result type.
`default_nettype none

module ffsp_alu
	import ffsp_pkg::*;
(
	input  wire logic [2:0]        op,
	input  wire logic [ADDR_W-1:0] a,
	input  wire logic [ADDR_W-1:0] b,
	input  wire logic [ADDR_W-1:0] c,
	output alu_res_t               res
);

	logic [ADDR_W-1:0] mask;
	logic [ADDR_W-1:0] sum;

	assign mask = b - 32'd1;

	always_comb begin
		sum = '0;
		res = '0;
		case (op)
			OP_ROUND: begin
				sum      = a + b;
				res.y    = sum & ~mask;
				res.flag = (a & mask) != '0;
			end
			OP_BANKCHK: begin
				sum      = (a & mask) + c;
				res.y    = sum;
				res.flag = (sum & ~mask) != '0;
			end
			OP_FIT: begin
				sum      = b - a;
				res.y    = sum;
				res.flag = (a < b) && (sum >= c);
			end
			OP_ADD: begin
				sum   = a + c;
				res.y = sum;
			end
			OP_HIT: begin
				res.flag = (a < b) && (c > b);
			end
			OP_GT: begin
				res.flag = a > b;
			end
			default: begin
				res = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/ffsp_mem.sv =====
// Boundary list storage: one write port and one read port with registered read data.
// Depends on ffsp_pkg for the data width.
`default_nettype none

module ffsp_mem
	import ffsp_pkg::*;
#(
	parameter int DEPTH = 2 * MAX_SEGMENTS_DEF + 2,
	localparam int AW   = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [AW-1:0]     wr_addr,
	input  wire logic [ADDR_W-1:0] wr_data,
	input  wire logic [AW-1:0]     rd_addr,
	output logic      [ADDR_W-1:0] rd_data
);

	logic [ADDR_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

// ===== rtl/first_fit_segment_placer_core.sv =====
// Top level of the first-fit segment placer: sequencer, request registers and result port.
// Depends on ffsp_pkg, ffsp_alu and ffsp_mem.
//
// Channel   Direction  Handshake                    Payload
// request   in         start while busy is low      mode, org_value, absolute_bank,
//                                                   override_address, seg_length,
//                                                   alignment, bank_size
// result    out        done, one cycle              placed_address, status
// config    in         cfg_we                       cfg_wdata (lowest address)
//
// A fixed request computes the segment end, scans each list entry for a collision and
// answers from FX_DEC if it collides or the list is full. A first-fit request visits FF_RD,
// FF_BASE, FF_END, FF_BANK, FF_FIT for each free run, and FF_BMOVE when the base moves to
// the next bank. A placement inserts two entries through INS_RD, INS_LOOP and INS_DONE. After
// reset and on a restart the list is loaded in INIT0 and INIT1 with busy high. The receiver
// cannot stall: each result is shown for one cycle with done high.
`default_nettype none

module first_fit_segment_placer_core
	import ffsp_pkg::*;
#(
	parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               mode,
	input  wire logic [ORG_W-1:0]   org_value,
	input  wire logic               absolute_bank,
	input  wire logic [ORG_W-1:0]   override_address,
	input  wire logic [FIELD_W-1:0] seg_length,
	input  wire logic [FIELD_W-1:0] alignment,
	input  wire logic [FIELD_W-1:0] bank_size,
	output logic                    done,
	output logic [ADDR_W-1:0]       placed_address,
	output logic [1:0]              status,
	input  wire logic               cfg_we,
	input  wire logic [FIELD_W-1:0] cfg_wdata
);

	localparam int LIST_CAP = 2 * MAX_SEGMENTS + 2;
	localparam int AW       = $clog2(LIST_CAP);
	localparam int CW       = $clog2(LIST_CAP + 1);

	localparam logic [4:0] S_IDLE     = 5'd0;
	localparam logic [4:0] S_INIT0    = 5'd1;
	localparam logic [4:0] S_INIT1    = 5'd2;
	localparam logic [4:0] S_FX_END   = 5'd3;
	localparam logic [4:0] S_FX_SCAN  = 5'd4;
	localparam logic [4:0] S_FX_DEC   = 5'd5;
	localparam logic [4:0] S_FF_RD    = 5'd6;
	localparam logic [4:0] S_FF_BASE  = 5'd7;
	localparam logic [4:0] S_FF_END   = 5'd8;
	localparam logic [4:0] S_FF_BANK  = 5'd9;
	localparam logic [4:0] S_FF_BMOVE = 5'd10;
	localparam logic [4:0] S_FF_FIT   = 5'd11;
	localparam logic [4:0] S_INS_RD   = 5'd12;
	localparam logic [4:0] S_INS_LOOP = 5'd13;
	localparam logic [4:0] S_INS_FIN  = 5'd14;
	localparam logic [4:0] S_INS_DONE = 5'd15;
	localparam logic [4:0] S_INS2     = 5'd16;

	logic [4:0]         state_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      idx_q;
	logic [FIELD_W-1:0] lowest_q;
	logic               restart_q;
	logic               hit_q;
	logic               second_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [ADDR_W-1:0]  seg_end_q;
	logic [ADDR_W-1:0]  first_q;
	logic [ADDR_W-1:0]  base_q;
	logic [ADDR_W-1:0]  run_end_q;
	logic [ADDR_W-1:0]  v_q;
	logic [FIELD_W-1:0] len_q;
	logic [FIELD_W-1:0] align_q;
	logic [FIELD_W-1:0] bank_q;

	logic [2:0]        alu_op;
	logic [ADDR_W-1:0] alu_a;
	logic [ADDR_W-1:0] alu_b;
	logic [ADDR_W-1:0] alu_c;
	alu_res_t          alu_res;

	logic              mem_we;
	logic [CW-1:0]     mem_wr_idx;
	logic [ADDR_W-1:0] mem_wr_data;
	logic [CW-1:0]     mem_rd_idx;
	logic [ADDR_W-1:0] mem_rd_data;

	logic [ADDR_W-1:0] len_ext;
	logic [ADDR_W-1:0] fixed_addr;
	logic [CW:0]       count_plus2;
	logic              room;
	logic [CW-1:0]     idx_next2;

	assign len_ext     = {{(ADDR_W - FIELD_W){1'b0}}, len_q};
	assign count_plus2 = {1'b0, count_q} + (CW + 1)'(2);
	assign room        = count_plus2 <= (CW + 1)'(LIST_CAP);
	assign idx_next2   = idx_q + CW'(2);
	assign busy        = state_q != S_IDLE;

	always_comb begin
		if (override_address != '0) begin
			fixed_addr = {{(ADDR_W - ORG_W){1'b0}}, override_address};
		end else if (absolute_bank) begin
			fixed_addr = {org_value[ADDR_W-BANK_SHIFT-1:0], {BANK_SHIFT{1'b0}}};
		end else begin
			fixed_addr = {{(ADDR_W - ORG_W){1'b0}}, org_value};
		end
	end

	ffsp_alu u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (alu_b),
		.c   (alu_c),
		.res (alu_res)
	);

	ffsp_mem #(
		.DEPTH (LIST_CAP)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.wr_addr (mem_wr_idx[AW-1:0]),
		.wr_data (mem_wr_data),
		.rd_addr (mem_rd_idx[AW-1:0]),
		.rd_data (mem_rd_data)
	);

	always_comb begin
		alu_op      = OP_ADD;
		alu_a       = addr_q;
		alu_b       = '0;
		alu_c       = len_ext;
		mem_we      = 1'b0;
		mem_wr_idx  = '0;
		mem_wr_data = '0;
		mem_rd_idx  = '0;
		case (state_q)
			S_INIT0: begin
				mem_we      = 1'b1;
				mem_wr_data = {{(ADDR_W - FIELD_W){1'b0}}, lowest_q};
			end
			S_INIT1: begin
				mem_we      = 1'b1;
				mem_wr_idx  = CW'(1);
				mem_wr_data = MEMORY_TOP;
			end
			S_FX_SCAN: begin
				alu_op     = OP_HIT;
				alu_b      = mem_rd_data;
				alu_c      = seg_end_q;
				mem_rd_idx = idx_q + CW'(1);
			end
			S_FX_DEC: begin
				alu_op      = OP_GT;
				alu_a       = first_q;
				alu_b       = addr_q;
				mem_we      = !hit_q && room && alu_res.flag;
				mem_wr_data = addr_q;
			end
			S_FF_RD: begin
				mem_rd_idx = idx_q;
			end
			S_FF_BASE: begin
				mem_rd_idx = idx_q + CW'(1);
			end
			S_FF_END: begin
				alu_op = OP_ROUND;
				alu_a  = base_q;
				alu_b  = {{(ADDR_W - FIELD_W){1'b0}}, align_q};
			end
			S_FF_BANK: begin
				alu_op = OP_BANKCHK;
				alu_a  = base_q;
				alu_b  = {{(ADDR_W - FIELD_W){1'b0}}, bank_q};
			end
			S_FF_BMOVE: begin
				alu_op = OP_ROUND;
				alu_a  = base_q;
				alu_b  = {{(ADDR_W - FIELD_W){1'b0}}, bank_q};
			end
			S_FF_FIT: begin
				alu_op = OP_FIT;
				alu_a  = base_q;
				alu_b  = run_end_q;
			end
			S_INS_RD: begin
				mem_rd_idx = count_q - CW'(1);
			end
			S_INS_LOOP: begin
				alu_op      = OP_GT;
				alu_a       = mem_rd_data;
				alu_b       = v_q;
				mem_rd_idx  = idx_q - CW'(2);
				mem_we      = 1'b1;
				mem_wr_idx  = idx_q;
				mem_wr_data = alu_res.flag ? mem_rd_data : v_q;
			end
			S_INS_FIN: begin
				mem_we      = 1'b1;
				mem_wr_data = v_q;
			end
			default: begin
				alu_op = OP_ADD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_INIT0;
			count_q   <= CW'(2);
			idx_q     <= '0;
			lowest_q  <= LOWEST_RESET;
			restart_q <= 1'b0;
			hit_q     <= 1'b0;
			second_q  <= 1'b0;
			done      <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cfg_we) begin
				lowest_q <= cfg_wdata;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						len_q   <= seg_length;
						align_q <= alignment;
						bank_q  <= bank_size;
						addr_q  <= fixed_addr;
						hit_q   <= 1'b0;
						idx_q   <= '0;
						if (mode) begin
							restart_q <= 1'b1;
							state_q   <= S_INIT0;
						end else if (override_address != '0 || org_value != '0) begin
							state_q <= S_FX_END;
						end else begin
							state_q <= S_FF_RD;
						end
					end
				end
				S_INIT0: begin
					state_q <= S_INIT1;
				end
				S_INIT1: begin
					count_q   <= CW'(2);
					restart_q <= 1'b0;
					if (restart_q) begin
						done           <= 1'b1;
						placed_address <= '0;
						status         <= ST_OK;
					end
					state_q <= S_IDLE;
				end
				S_FX_END: begin
					seg_end_q <= alu_res.y;
					state_q   <= S_FX_SCAN;
				end
				S_FX_SCAN: begin
					if (alu_res.flag) begin
						hit_q <= 1'b1;
					end
					if (idx_q == '0) begin
						first_q <= mem_rd_data;
					end
					if (idx_q + CW'(1) < count_q) begin
						idx_q <= idx_q + CW'(1);
					end else begin
						state_q <= S_FX_DEC;
					end
				end
				S_FX_DEC: begin
					if (hit_q) begin
						done           <= 1'b1;
						placed_address <= '0;
						status         <= ST_COLLIDE;
						state_q        <= S_IDLE;
					end else if (!room) begin
						done           <= 1'b1;
						placed_address <= '0;
						status         <= ST_FULL;
						state_q        <= S_IDLE;
					end else begin
						v_q      <= addr_q;
						second_q <= 1'b0;
						state_q  <= S_INS_RD;
					end
				end
				S_FF_RD: begin
					state_q <= S_FF_BASE;
				end
				S_FF_BASE: begin
					base_q  <= mem_rd_data;
					state_q <= S_FF_END;
				end
				S_FF_END: begin
					run_end_q <= mem_rd_data;
					if (align_q != '0 && alu_res.flag) begin
						base_q <= alu_res.y;
					end
					state_q <= S_FF_BANK;
				end
				S_FF_BANK: begin
					if (bank_q != '0 && alu_res.flag) begin
						state_q <= S_FF_BMOVE;
					end else begin
						state_q <= S_FF_FIT;
					end
				end
				S_FF_BMOVE: begin
					base_q  <= alu_res.y;
					state_q <= S_FF_FIT;
				end
				S_FF_FIT: begin
					if (alu_res.flag) begin
						if (!room) begin
							done           <= 1'b1;
							placed_address <= '0;
							status         <= ST_FULL;
							state_q        <= S_IDLE;
						end else begin
							addr_q   <= base_q;
							v_q      <= base_q;
							second_q <= 1'b0;
							state_q  <= S_INS_RD;
						end
					end else if (idx_next2 + CW'(1) < count_q) begin
						idx_q   <= idx_next2;
						state_q <= S_FF_RD;
					end else begin
						done           <= 1'b1;
						placed_address <= '0;
						status         <= ST_NOSPACE;
						state_q        <= S_IDLE;
					end
				end
				S_INS_RD: begin
					idx_q   <= count_q;
					state_q <= S_INS_LOOP;
				end
				S_INS_LOOP: begin
					if (alu_res.flag) begin
						idx_q <= idx_q - CW'(1);
						if (idx_q == CW'(1)) begin
							state_q <= S_INS_FIN;
						end
					end else begin
						state_q <= S_INS_DONE;
					end
				end
				S_INS_FIN: begin
					state_q <= S_INS_DONE;
				end
				S_INS_DONE: begin
					count_q <= count_q + CW'(1);
					if (!second_q) begin
						second_q <= 1'b1;
						state_q  <= S_INS2;
					end else begin
						done           <= 1'b1;
						placed_address <= addr_q;
						status         <= ST_OK;
						state_q        <= S_IDLE;
					end
				end
				S_INS2: begin
					v_q     <= alu_res.y;
					state_q <= S_INS_RD;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== bench/first_fit_segment_placer_core_test.sv =====
// Self-checking bench for first_fit_segment_placer_core: directed requests, then random placement
// sequences under several configurations and sender idle rates.
// Depends on ffsp_pkg and first_fit_segment_placer_core.

module first_fit_segment_placer_core_test;
	import ffsp_pkg::*;

	localparam int LIST_DEPTH = 2 * MAX_SEGMENTS_DEF + 2;
	localparam logic MODE_PLACE = 1'b0;
	localparam logic MODE_RESTART = 1'b1;
	localparam logic [FIELD_W-1:0] FIELD_MAX = 25'h100_0000;
	localparam logic [ORG_W-1:0] ORG_MAX = 24'hFF_FFFF;
	localparam int SETTLE_CYCLES = 400;
	localparam int PHASE_ITEMS = 215;
	localparam int NUM_PHASES = 6;
	localparam int REPORT_LIMIT = 10;

	typedef struct {
		logic               mode;
		logic [ORG_W-1:0]   org_value;
		logic               absolute_bank;
		logic [ORG_W-1:0]   override_address;
		logic [FIELD_W-1:0] seg_length;
		logic [FIELD_W-1:0] alignment;
		logic [FIELD_W-1:0] bank_size;
	} request_t;

	typedef struct {
		logic [ADDR_W-1:0] addr;
		logic [1:0]        status;
	} placement_t;

	class boundary_tracker;
		logic [ADDR_W-1:0] bounds [LIST_DEPTH];
		int unsigned count;
		logic [FIELD_W-1:0] lowest;
		placement_t expected_placements [$];
		int unsigned mismatches;

		function new();
			lowest = LOWEST_RESET;
			mismatches = 0;
			reload();
		endfunction

		function void reload();
			foreach (bounds[i]) bounds[i] = '0;
			bounds[0] = ADDR_W'(lowest);
			bounds[1] = MEMORY_TOP;
			count = 2;
		endfunction

		function void insert_bound(logic [ADDR_W-1:0] v);
			int unsigned i;
			i = count;
			while (i > 0 && bounds[i-1] > v) begin
				bounds[i] = bounds[i-1];
				i--;
			end
			bounds[i] = v;
			count++;
		endfunction

		function void resort();
			logic [ADDR_W-1:0] v;
			int unsigned j;
			for (int unsigned i = 1; i < count; i++) begin
				v = bounds[i];
				j = i;
				while (j > 0 && bounds[j-1] > v) begin
					bounds[j] = bounds[j-1];
					j--;
				end
				bounds[j] = v;
			end
		endfunction

		function placement_t place_segment(request_t r);
			placement_t res;
			logic [ADDR_W-1:0] len, align, bank, base, fin, sum, spill;
			bit room, hit, found;
			len = ADDR_W'(r.seg_length);
			align = ADDR_W'(r.alignment);
			bank = ADDR_W'(r.bank_size);
			res.addr = '0;
			res.status = ST_OK;
			room = count + 2 <= LIST_DEPTH;
			hit = 1'b0;
			found = 1'b0;
			if (r.mode == MODE_RESTART) begin
				reload();
			end else if (r.override_address != 0 || r.org_value != 0) begin
				if (r.override_address != 0)
					base = ADDR_W'(r.override_address);
				else if (r.absolute_bank)
					base = ADDR_W'(r.org_value) << BANK_SHIFT;
				else
					base = ADDR_W'(r.org_value);
				sum = base + len;
				for (int unsigned i = 0; i < count; i++)
					if (base < bounds[i] && sum > bounds[i])
						hit = 1'b1;
				if (hit) begin
					res.status = ST_COLLIDE;
				end else if (!room) begin
					res.status = ST_FULL;
				end else begin
					if (base < bounds[0]) begin
						bounds[0] = base;
						resort();
					end
					insert_bound(base);
					insert_bound(sum);
					res.addr = base;
				end
			end else begin
				for (int unsigned i = 0; i + 1 < count && !found; i += 2) begin
					base = bounds[i];
					fin = bounds[i+1];
					if (align != 0 && (base & (align - 1)) != 0)
						base = (base + align) & ~(align - 1);
					if (bank != 0) begin
						spill = ((base & (bank - 1)) + len) & ~(bank - 1);
						if (spill != 0)
							base = (base + bank) & ~(bank - 1);
					end
					if (base < fin && fin - base >= len) begin
						res.addr = base;
						found = 1'b1;
					end
				end
				if (!found) begin
					res.status = ST_NOSPACE;
				end else if (!room) begin
					res.addr = '0;
					res.status = ST_FULL;
				end else begin
					sum = res.addr + len;
					insert_bound(res.addr);
					insert_bound(sum);
				end
			end
			return res;
		endfunction

		function void note_request(request_t r);
			expected_placements.push_back(place_segment(r));
		endfunction

		function void check_placement(logic [ADDR_W-1:0] addr, logic [1:0] st);
			placement_t want;
			if (expected_placements.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("Result with nothing expected: address %h status %0d", addr, st);
			end else begin
				want = expected_placements.pop_front();
				if (want.addr !== addr || want.status !== st) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("Mismatch: address expected %h got %h, status expected %0d got %0d",
							want.addr, addr, want.status, st);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic mode = 1'b0;
	logic [ORG_W-1:0] org_value = '0;
	logic absolute_bank = 1'b0;
	logic [ORG_W-1:0] override_address = '0;
	logic [FIELD_W-1:0] seg_length = '0;
	logic [FIELD_W-1:0] alignment = '0;
	logic [FIELD_W-1:0] bank_size = '0;
	logic done;
	logic [ADDR_W-1:0] placed_address;
	logic [1:0] status;
	logic cfg_we = 1'b0;
	logic [FIELD_W-1:0] cfg_wdata = '0;

	boundary_tracker tracker;
	logic [FIELD_W-1:0] phase_lowest [NUM_PHASES];
	int phase_idle [NUM_PHASES] = '{0, 75, 0, 9, 75, 9};

	first_fit_segment_placer_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.org_value(org_value),
		.absolute_bank(absolute_bank),
		.override_address(override_address),
		.seg_length(seg_length),
		.alignment(alignment),
		.bank_size(bank_size),
		.done(done),
		.placed_address(placed_address),
		.status(status),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic request_t compose(logic md, logic [ORG_W-1:0] org, logic absb,
		logic [ORG_W-1:0] ovr, logic [FIELD_W-1:0] len, logic [FIELD_W-1:0] algn,
		logic [FIELD_W-1:0] bnk);
		request_t r;
		r.mode = md;
		r.org_value = org;
		r.absolute_bank = absb;
		r.override_address = ovr;
		r.seg_length = len;
		r.alignment = algn;
		r.bank_size = bnk;
		return r;
	endfunction

	function automatic logic rand_bit();
		return 1'($urandom_range(1));
	endfunction

	function automatic logic [FIELD_W-1:0] rand_field();
		return FIELD_W'($urandom_range(FIELD_MAX));
	endfunction

	function automatic logic [FIELD_W-1:0] pick_scale(int zero_pct, int max_shift);
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < zero_pct)
			return '0;
		if (sel < 90)
			return FIELD_W'(1) << $urandom_range(max_shift);
		return rand_field();
	endfunction

	function automatic logic [FIELD_W-1:0] pick_length();
		if ($urandom_range(9) == 0)
			return rand_field();
		return FIELD_W'($urandom_range(32'd1 << $urandom_range(12)));
	endfunction

	function automatic logic [ORG_W-1:0] rand_origin();
		if ($urandom_range(3) == 0)
			return '0;
		return ORG_W'($urandom);
	endfunction

	function automatic request_t make_fixed();
		request_t r;
		int unsigned pick;
		r = compose(MODE_PLACE, '0, rand_bit(), '0, pick_length(), rand_field(), rand_field());
		pick = $urandom_range(2);
		if (pick == 0) begin
			r.override_address = ORG_W'($urandom_range(ORG_MAX));
			r.org_value = rand_origin();
		end else if (pick == 1) begin
			r.org_value = ORG_W'($urandom_range(ORG_MAX));
			r.absolute_bank = 1'b0;
		end else begin
			r.org_value = ORG_W'($urandom_range(1, 255));
			r.absolute_bank = 1'b1;
		end
		if (r.override_address == 0 && r.org_value == 0)
			r.org_value = ORG_W'(1);
		return r;
	endfunction

	function automatic request_t make_fit();
		return compose(MODE_PLACE, '0, rand_bit(), '0, pick_length(),
			pick_scale(25, 12), pick_scale(40, 24));
	endfunction

	function automatic request_t make_noise(logic md);
		return compose(md, rand_origin(), rand_bit(), rand_origin(),
			rand_field(), rand_field(), rand_field());
	endfunction

	task automatic send_request(request_t r, int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		mode <= r.mode;
		org_value <= r.org_value;
		absolute_bank <= r.absolute_bank;
		override_address <= r.override_address;
		seg_length <= r.seg_length;
		alignment <= r.alignment;
		bank_size <= r.bank_size;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
	endtask

	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (tracker.expected_placements.size() != 0 || busy !== 1'b0)
			@(posedge clk);
	endtask

	task automatic write_lowest(logic [FIELD_W-1:0] v);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.lowest = v;
	endtask

	task automatic run_phase(int idle_pct);
		int sent, nfixed, nfit, nnoise;
		sent = 0;
		while (sent < PHASE_ITEMS) begin
			if ($urandom_range(99) < 85) begin
				send_request(make_noise(MODE_RESTART), idle_pct);
				nfixed = $urandom_range(3);
				nfit = ($urandom_range(3) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12);
				repeat (nfixed) send_request(make_fixed(), idle_pct);
				repeat (nfit) send_request(make_fit(), idle_pct);
				sent += 1 + nfixed + nfit;
			end else begin
				nnoise = $urandom_range(1, 5);
				repeat (nnoise)
					send_request(make_noise(($urandom_range(9) == 0) ? MODE_RESTART : MODE_PLACE),
						idle_pct);
				sent += nnoise;
			end
		end
	endtask

	always @(posedge clk) begin
		if (done === 1'b1)
			tracker.check_placement(placed_address, status);
		if (arst_n && start && busy === 1'b0)
			tracker.note_request(compose(mode, org_value, absolute_bank, override_address,
				seg_length, alignment, bank_size));
	end

	initial begin
		#80_000_000;
		$display("FAIL first_fit_segment_placer_core");
		$finish;
	end

	initial begin
		tracker = new();
		phase_lowest = '{25'h0, 25'h0, FIELD_MAX, LOWEST_RESET, 25'h0, 25'h0};
		phase_lowest[1] = rand_field();
		phase_lowest[4] = FIELD_W'($urandom_range(16'hFFFF));
		phase_lowest[5] = rand_field();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		send_request(compose(MODE_PLACE, '0, 1'b0, '0, 25'h100, '0, '0), 0);
		send_request(compose(MODE_PLACE, '0, 1'b0, 24'h03_0000, 25'h1000, '0, '0), 0);
		send_request(compose(MODE_PLACE, 24'h04_0000, 1'b0, '0, 25'h10, '0, '0), 0);
		send_request(compose(MODE_PLACE, 24'h5, 1'b1, '0, 25'h100, '0, '0), 0);
		send_request(compose(MODE_PLACE, '0, 1'b0, 24'h02_FFF0, 25'h100, '0, '0), 0);
		send_request(compose(MODE_PLACE, '0, 1'b0, 24'h100, 25'h10, '0, '0), 0);
		send_request(compose(MODE_PLACE, '0, 1'b0, '0, 25'h20, 25'h1000, '0), 0);
		send_request(compose(MODE_PLACE, '0, 1'b0, '0, 25'h8000, '0, 25'h1_0000), 0);
		send_request(compose(MODE_PLACE, '0, 1'b1, '0, FIELD_MAX, '0, '0), 0);
		send_request(compose(MODE_PLACE, '0, 1'b0, '0, 25'h40, 25'h3000, 25'h5000), 0);
		send_request(compose(MODE_PLACE, '0, 1'b0, ORG_MAX, FIELD_MAX, '0, '0), 0);
		send_request(compose(MODE_PLACE, ORG_MAX, 1'b1, '0, FIELD_MAX, '0, '0), 0);
		send_request(compose(MODE_RESTART, ORG_MAX, 1'b1, ORG_MAX, FIELD_MAX, FIELD_MAX,
			FIELD_MAX), 0);

		// With the lowest boundary at zero, first fit may legitimately place at address zero.
		write_lowest('0);
		send_request(compose(MODE_RESTART, '0, 1'b0, '0, '0, '0, '0), 0);
		send_request(compose(MODE_PLACE, '0, 1'b0, '0, '0, FIELD_MAX, FIELD_MAX), 0);
		send_request(compose(MODE_PLACE, '0, 1'b0, 24'h1000, FIELD_MAX, '0, '0), 0);
		send_request(compose(MODE_PLACE, 24'h1, 1'b0, '0, '0, '0, '0), 0);
		send_request(compose(MODE_PLACE, '0, 1'b1, '0, FIELD_MAX, FIELD_MAX, FIELD_MAX), 0);

		for (int p = 0; p < NUM_PHASES; p++) begin
			write_lowest(phase_lowest[p]);
			run_phase(phase_idle[p]);
		end

		settle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.expected_placements.size() == 0)
			$display("PASS first_fit_segment_placer_core");
		else
			$display("FAIL first_fit_segment_placer_core");
		$finish;
	end

endmodule
